/* hdl/utf8sd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types, constants and the byte classifier for the UTF-8 stream
// decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } byte_class_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
    } result_t;

    // results handed from the decoder to the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
        byte_class_t cls;
        priority casez (b[7:3])
            5'b0????: cls = CLS_ASCII;
            5'b10???: cls = CLS_CONT;
            5'b110??: cls = CLS_LEAD2;
            5'b1110?: cls = CLS_LEAD3;
            5'b11110: cls = CLS_LEAD4;
            default:  cls = CLS_INVALID;
        endcase
        return cls;
    endfunction

endpackage

/* hdl/utf8sd_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_byte_if
// Valid/ready channel carrying one raw input byte per transaction.
// ----------------------------------------------------------------------------
interface utf8sd_byte_if;
    import utf8sd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

/* hdl/utf8sd_cp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_cp_if
// Valid/ready channel carrying one decoded code point per transaction.
// ----------------------------------------------------------------------------
interface utf8sd_cp_if;
    import utf8sd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            last;

    modport source (output valid, output code_point, output last, input ready);
    modport sink   (input valid, input code_point, input last, output ready);
endinterface

/* hdl/utf8sd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_core
// Input byte register, pending sequence state and combinational decode of
// one byte into zero, one or two results.
// ----------------------------------------------------------------------------
module utf8sd_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [utf8sd_pkg::BYTE_W-1:0] in_byte,
    input  logic                        room2,
    output utf8sd_pkg::push_t           push
);
    import utf8sd_pkg::*;

    logic              byte_valid_reg;
    logic              byte_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [1:0]        pend_count_reg;
    logic [1:0]        pend_count_next;
    logic [CP_W-1:0]   pend_value_reg;
    logic [CP_W-1:0]   pend_value_next;

    logic              advance;
    logic              in_take;
    byte_class_t       cls;
    logic [1:0]        count_dec;
    logic [CP_W-1:0]   cont_bits;
    logic [CP_W-1:0]   cont_value;
    logic [CP_W-1:0]   ascii_value;
    push_t             push_comb;

    assign advance  = byte_valid_reg && room2;
    assign in_ready = !byte_valid_reg || room2;
    assign in_take  = in_valid && in_ready;

    assign cls         = classify(byte_reg);
    assign count_dec   = pend_count_reg - 2'd1;
    assign cont_value  = pend_value_reg | cont_bits;
    assign ascii_value = {14'b0, byte_reg[6:0]};

    // continuation payload placed at six times the count still expected
    always_comb
    begin
        unique case (count_dec)
            2'd0:    cont_bits = {15'b0, byte_reg[5:0]};
            2'd1:    cont_bits = {9'b0, byte_reg[5:0], 6'b0};
            2'd2:    cont_bits = {3'b0, byte_reg[5:0], 12'b0};
            default: cont_bits = '0;
        endcase
    end

    always_comb
    begin
        pend_count_next = pend_count_reg;
        pend_value_next = pend_value_reg;
        push_comb       = '0;
        unique case (cls)
            CLS_CONT:
            begin
                if (pend_count_reg != 2'd0)
                begin
                    pend_count_next = count_dec;
                    pend_value_next = cont_value;
                    if (count_dec == 2'd0)
                    begin
                        push_comb.count = 2'd1;
                        push_comb.first = '{code_point: cont_value, last: 1'b1};
                    end
                end
            end
            CLS_ASCII:
            begin
                pend_count_next = 2'd0;
                if (pend_count_reg != 2'd0)
                begin
                    push_comb.count  = 2'd2;
                    push_comb.first  = '{code_point: REPLACEMENT_CHAR, last: 1'b0};
                    push_comb.second = '{code_point: ascii_value, last: 1'b1};
                end
                else
                begin
                    push_comb.count = 2'd1;
                    push_comb.first = '{code_point: ascii_value, last: 1'b1};
                end
            end
            CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
            begin
                if (pend_count_reg != 2'd0)
                begin
                    push_comb.count = 2'd1;
                    push_comb.first = '{code_point: REPLACEMENT_CHAR, last: 1'b1};
                end
                unique case (cls)
                    CLS_LEAD2:
                    begin
                        pend_count_next = 2'd1;
                        pend_value_next = {10'b0, byte_reg[4:0], 6'b0};
                    end
                    CLS_LEAD3:
                    begin
                        pend_count_next = 2'd2;
                        pend_value_next = {5'b0, byte_reg[3:0], 12'b0};
                    end
                    default:
                    begin
                        pend_count_next = 2'd3;
                        pend_value_next = {byte_reg[2:0], 18'b0};
                    end
                endcase
            end
            default:
            begin
                // invalid byte dropped, pending sequence kept
            end
        endcase
    end

    always_comb
    begin
        if (in_take)
            byte_valid_next = 1'b1;
        else if (advance)
            byte_valid_next = 1'b0;
        else
            byte_valid_next = byte_valid_reg;
    end

    always_comb
    begin
        push = push_comb;
        if (!advance)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            pend_count_reg <= 2'd0;
            pend_value_reg <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            if (advance)
            begin
                pend_count_reg <= pend_count_next;
                pend_value_reg <= pend_value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= in_byte;
    end

endmodule

/* hdl/utf8sd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_fifo
// Result queue taking up to two results per cycle and giving one per
// output transaction.
// ----------------------------------------------------------------------------
module utf8sd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  utf8sd_pkg::push_t            push,
    output logic                         room2,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [utf8sd_pkg::CP_W-1:0]  out_code_point,
    output logic                         out_last
);
    import utf8sd_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    result_t           mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_inc;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;
    result_t           head;

    assign head           = mem[rd_ptr_reg];
    assign out_valid      = count_reg != '0;
    assign out_code_point = head.code_point;
    assign out_last       = head.last;
    assign pop            = out_valid && out_ready;
    assign room2          = count_reg <= CNT_W'(DEPTH - 2);

    assign wr_ptr_inc  = wr_ptr_reg + ADDR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + ADDR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + ADDR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_inc] <= push.second;
    end

endmodule

/* hdl/utf8_stream_decoder_top.sv */
`timescale 1ns / 1ps
// path: a byte is held in the input byte register, decoded there and its
//   results written into the result queue, whose head is offered
// throughput: one byte per cycle while each byte yields at most one result
//   and the output is not stalled; a byte that yields two results needs two
//   output transactions, as the result queue gives one result per cycle
// reset: asynchronous, clears pending sequence, input register and queue
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream decoder: one raw byte in, decoded code points out, with
// U+FFFD for an interrupted sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    utf8sd_byte_if.sink      byte_stream,
    utf8sd_cp_if.source      cp_stream
);
    import utf8sd_pkg::*;

    push_t push;
    logic  room2;

    utf8sd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_stream.valid),
        .in_ready (byte_stream.ready),
        .in_byte  (byte_stream.byte_in),
        .room2    (room2),
        .push     (push)
    );

    utf8sd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .room2          (room2),
        .out_valid      (cp_stream.valid),
        .out_ready      (cp_stream.ready),
        .out_code_point (cp_stream.code_point),
        .out_last       (cp_stream.last)
    );

endmodule

/* hdl/utf8sd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module utf8sd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [utf8sd_pkg::CP_W-1:0] out_code_point,
    input logic                        out_last
);
    import utf8sd_pkg::*;

    // stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_code_point) && $stable(out_last))
    else $error("result payload changed while stalled");

    // only the replacement for an interrupted sequence is not last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_code_point == REPLACEMENT_CHAR)
    else $error("non-final result is not the replacement character");

    // the result that ends the byte is already queued behind a non-final one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("final result missing after replacement character");

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (cp_stream.valid),
    .out_ready      (cp_stream.ready),
    .out_code_point (cp_stream.code_point),
    .out_last       (cp_stream.last)
);

/* verif/tb_utf8_stream_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_top
// Drives raw bytes into the UTF-8 stream decoder and checks every decoded
// code point against a byte-level decoder kept in the scoreboard. A short
// directed stream covers each byte class, the extreme code points, stray
// and invalid bytes and interrupted sequences. Random sequences follow,
// mostly well formed, mixed with truncated sequences, stray continuations,
// invalid bytes and noise. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_top;
    import utf8sd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 725;
    localparam int IDLE_PCT     = 31;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    class code_point_board;
        logic [1:0]      conts_left;
        logic [CP_W-1:0] partial_cp;
        result_t         due_cps[$];
        int              fail_cnt;

        function new();
            conts_left = '0;
            partial_cp = '0;
            fail_cnt   = 0;
        endfunction

        // returns 1 when the decoder drops the byte without any effect
        function bit note_byte(input logic [BYTE_W-1:0] b);
            byte_class_t cls;
            casez (b[7:3])
                5'b0????: cls = CLS_ASCII;
                5'b10???: cls = CLS_CONT;
                5'b110??: cls = CLS_LEAD2;
                5'b1110?: cls = CLS_LEAD3;
                5'b11110: cls = CLS_LEAD4;
                default:  cls = CLS_INVALID;
            endcase
            case (cls)
                CLS_INVALID:
                    return 1'b1;
                CLS_CONT:
                begin
                    if (conts_left == 2'd0)
                        return 1'b1;
                    conts_left = conts_left - 2'd1;
                    partial_cp = partial_cp | (CP_W'(b[5:0]) << (6 * conts_left));
                    if (conts_left == 2'd0)
                        due_cps.push_back(result_t'{code_point: partial_cp, last: 1'b1});
                end
                CLS_ASCII:
                begin
                    if (conts_left != 2'd0)
                        due_cps.push_back(result_t'{code_point: REPLACEMENT_CHAR,
                                                    last: 1'b0});
                    conts_left = 2'd0;
                    due_cps.push_back(result_t'{code_point: CP_W'(b[6:0]), last: 1'b1});
                end
                default:
                begin
                    if (conts_left != 2'd0)
                        due_cps.push_back(result_t'{code_point: REPLACEMENT_CHAR,
                                                    last: 1'b1});
                    case (cls)
                        CLS_LEAD2:
                        begin
                            conts_left = 2'd1;
                            partial_cp = CP_W'(b[4:0]) << 6;
                        end
                        CLS_LEAD3:
                        begin
                            conts_left = 2'd2;
                            partial_cp = CP_W'(b[3:0]) << 12;
                        end
                        default:
                        begin
                            conts_left = 2'd3;
                            partial_cp = CP_W'(b[2:0]) << 18;
                        end
                    endcase
                end
            endcase
            return 1'b0;
        endfunction

        function void check_result(input logic [CP_W-1:0] cp, input logic last);
            result_t want;
            if (due_cps.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("unexpected code point %h last %b at %0t", cp, last, $time);
                return;
            end
            want = due_cps.pop_front();
            if (cp !== want.code_point || last !== want.last)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("mismatch at %0t: code_point exp %h got %h, last exp %b got %b",
                             $time, want.code_point, cp, want.last, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    int   counted;
    int   cycle_cnt;

    code_point_board board;

    utf8sd_byte_if byte_if ();
    utf8sd_cp_if   cp_if ();

    utf8_stream_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .cp_stream   (cp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        cp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && cp_if.valid && cp_if.ready)
            board.check_result(cp_if.code_point, cp_if.last);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            byte_if.valid <= 1'b0;
            @(negedge clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.byte_in <= b;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        void'(board.note_byte(b));
        counted++;
        @(negedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] lead_byte(input int len);
        case (len)
            1:       return {1'b0, 7'($urandom)};
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    task automatic send_random_seq();
        int pick;
        int len;
        int spot;
        pick = $urandom_range(99);
        len  = $urandom_range(1, 4);
        if (pick < 70)
        begin
            send_byte(lead_byte(len));
            for (int i = 1; i < len; i++)
                send_byte({2'b10, 6'($urandom)});
        end
        else if (pick < 80)
        begin
            // truncated sequence, the next lead or ascii interrupts it
            len = $urandom_range(2, 4);
            send_byte(lead_byte(len));
            for (int i = $urandom_range(0, len - 2); i > 0; i--)
                send_byte({2'b10, 6'($urandom)});
        end
        else if (pick < 87)
            send_byte({2'b10, 6'($urandom)});
        else if (pick < 93)
        begin
            // invalid byte dropped inside a sequence
            len  = $urandom_range(2, 4);
            spot = $urandom_range(1, len - 1);
            send_byte(lead_byte(len));
            for (int i = 1; i < len; i++)
            begin
                if (i == spot)
                    send_byte({5'b11111, 3'($urandom)});
                send_byte({2'b10, 6'($urandom)});
            end
        end
        else
            send_byte(8'($urandom));
    endtask

    initial
    begin
        logic [BYTE_W-1:0] directed[$];
        directed = '{8'h00, 8'h7F,
                     8'hC2, 8'hA9,
                     8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'h80,
                     8'hF8, 8'hFF,
                     8'hC3, 8'h41,
                     8'hE2, 8'hC3, 8'hA9,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hC0, 8'h80};
        board           = new();
        clk             = 1'b0;
        rst_n           = 1'b0;
        calm            = 1'b0;
        counted         = 0;
        cycle_cnt       = 0;
        byte_if.valid   = 1'b0;
        byte_if.byte_in = '0;
        cp_if.ready     = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= 300 && counted < 450);
            send_random_seq();
        end
        calm          = 1'b0;
        byte_if.valid <= 1'b0;

        while (board.due_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.fail_cnt == 0 && board.due_cps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
hdl/utf8sd_pkg.sv
hdl/utf8sd_byte_if.sv
hdl/utf8sd_cp_if.sv
hdl/utf8sd_core.sv
hdl/utf8sd_fifo.sv
hdl/utf8_stream_decoder_top.sv
hdl/utf8sd_checker.sv
verif/tb_utf8_stream_decoder_top.sv
